// File: rtl/ngp_pkg.sv
`timescale 1ns / 1ps

package ngp_pkg;

    // Default number of minute fraction digits kept
    localparam int MINUTE_FRACTION_DIGITS_DEFAULT = 5;

    // Result field widths
    localparam int TIME_W    = 19;
    localparam int LAT_W     = 27;
    localparam int LON_W     = 30;
    localparam int HEM_W     = 8;
    localparam int LAT_DEG_W = 7;
    localparam int LON_DEG_W = 10;
    localparam int ANGLE_W   = 30;
    localparam int MICRO     = 1000000;

    // Character codes
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_POINT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Field numbers within a sentence
    localparam logic [2:0] FIELD_HEADER  = 3'd0;
    localparam logic [2:0] FIELD_TIME    = 3'd1;
    localparam logic [2:0] FIELD_LAT     = 3'd2;
    localparam logic [2:0] FIELD_LAT_HEM = 3'd3;
    localparam logic [2:0] FIELD_LON     = 3'd4;
    localparam logic [2:0] FIELD_LON_HEM = 3'd5;
    localparam logic [2:0] FIELD_DONE    = 3'd6;
    localparam logic [2:0] FIELD_MAX     = 3'd7;

    // Character position limits
    localparam logic [2:0] CPOS_MAX       = 3'd7;
    localparam logic [2:0] HEADER_LEN     = 3'd5;
    localparam logic [2:0] TIME_DIGITS    = 3'd6;
    localparam logic [2:0] LAT_DEG_DIGITS = 3'd2;
    localparam logic [2:0] LON_DEG_DIGITS = 3'd3;

    // Fraction digit count marking a finished minute number
    localparam logic [2:0] FRAC_DONE = 3'd7;

    // Sentence fields that do not depend on the fraction digit count
    typedef struct packed {
        logic [TIME_W-1:0]    time_seconds;
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [HEM_W-1:0]     lat_hem;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [HEM_W-1:0]     lon_hem;
    } fix_fields_t;

    // Stage enables of the conversion pipeline
    typedef struct packed {
        logic a;
        logic b;
        logic o;
    } pipe_en_t;

    // Power of ten, elaboration use only
    function automatic longint unsigned pow10(input int n);
        longint unsigned v;
        v = 1;
        for (int k = 0; k < n && k < 12; k++)
        begin
            v = v * 10;
        end
        return v;
    endfunction

    // Width of the minute accumulator
    function automatic int minute_w(input int fd);
        return $clog2(100 * pow10(fd));
    endfunction

    // Expected header character by position
    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h47;
            3'd1:    ch = 8'h50;
            3'd2:    ch = 8'h47;
            3'd3:    ch = 8'h47;
            3'd4:    ch = 8'h41;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Weight of a time digit by position (hh mm ss)
    function automatic logic [15:0] time_weight(input logic [2:0] pos);
        logic [15:0] w;
        case (pos)
            3'd0:    w = 16'd36000;
            3'd1:    w = 16'd3600;
            3'd2:    w = 16'd600;
            3'd3:    w = 16'd60;
            3'd4:    w = 16'd10;
            3'd5:    w = 16'd1;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

    // Weight of a longitude degree digit by position
    function automatic logic [6:0] lon_deg_weight(input logic [2:0] pos);
        logic [6:0] w;
        case (pos)
            3'd0:    w = 7'd100;
            3'd1:    w = 7'd10;
            3'd2:    w = 7'd1;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/ngp_char_parser.sv
`timescale 1ns / 1ps

module ngp_char_parser #(
    parameter int MINUTE_FRACTION_DIGITS = ngp_pkg::MINUTE_FRACTION_DIGITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rx_valid,
    output logic                      rx_ready,
    input  logic [7:0]                rx_byte,
    output logic                      fix_valid,
    input  logic                      fix_ready,
    output ngp_pkg::fix_fields_t      fix,
    output logic [ngp_pkg::minute_w(MINUTE_FRACTION_DIGITS)-1:0] lat_minutes,
    output logic [ngp_pkg::minute_w(MINUTE_FRACTION_DIGITS)-1:0] lon_minutes
);

    localparam int FD = MINUTE_FRACTION_DIGITS;
    localparam int MW = ngp_pkg::minute_w(FD);
    localparam int VW = MW + 4;
    localparam logic [MW-1:0] MAXV  = MW'(100 * ngp_pkg::pow10(FD) - 1);
    localparam logic [VW-1:0] SCALE = VW'(ngp_pkg::pow10(FD));

    // Sentence state
    logic                           in_sentence_reg, in_sentence_next;
    logic [2:0]                     field_reg, field_next;
    logic [2:0]                     cpos_reg, cpos_next;
    logic                           header_ok_reg, header_ok_next;
    logic [ngp_pkg::TIME_W-1:0]     time_reg, time_next;
    logic [ngp_pkg::LON_DEG_W-1:0]  deg_reg, deg_next;
    logic [MW-1:0]                  min_reg, min_next;
    logic [2:0]                     fds_reg, fds_next;
    logic                           point_reg, point_next;
    logic [ngp_pkg::LAT_DEG_W-1:0]  lat_deg_reg, lat_deg_next;
    logic [MW-1:0]                  lat_min_reg, lat_min_next;
    logic [ngp_pkg::HEM_W-1:0]      lat_hem_reg, lat_hem_next;
    logic [ngp_pkg::HEM_W-1:0]      lon_hem_reg, lon_hem_next;

    // Result register
    logic                           fix_valid_reg, fix_valid_next;
    ngp_pkg::fix_fields_t           fix_reg;
    logic [MW-1:0]                  lat_min_out_reg;
    logic [MW-1:0]                  lon_min_out_reg;

    logic                           accept;
    logic                           emit;
    logic                           is_digit;
    logic [3:0]                     digit;
    logic [MW-1:0]                  frac_weight [8];

    // Minute digit unit outputs
    logic [MW-1:0]                  mc_min;
    logic [2:0]                     mc_fds;
    logic                           mc_point;
    logic [VW-1:0]                  mc_wide;
    logic                           mc_upd;

    assign rx_ready = !fix_valid_reg || fix_ready;
    assign accept   = rx_valid && rx_ready;
    assign is_digit = rx_byte inside {[ngp_pkg::CHAR_ZERO:ngp_pkg::CHAR_NINE]};
    assign digit    = is_digit ? rx_byte[3:0] : 4'd0;

    // Weight of each fraction digit, zero past the kept digits
    for (genvar g = 0; g < 8; g++)
    begin : g_frac_w
        if (g < FD)
        begin : g_used
            assign frac_weight[g] = MW'(ngp_pkg::pow10(FD - 1 - g));
        end
        else
        begin : g_unused
            assign frac_weight[g] = '0;
        end
    end

    // Minute digit unit: shift in integer digits, add weighted fraction digits
    always_comb
    begin
        mc_min   = min_reg;
        mc_fds   = fds_reg;
        mc_point = point_reg;
        mc_wide  = '0;
        mc_upd   = 1'b0;
        if (is_digit)
        begin
            if (!point_reg)
            begin
                mc_wide = VW'(min_reg) * VW'(10) + VW'(digit) * SCALE;
                mc_upd  = 1'b1;
            end
            else if (fds_reg < 3'(FD))
            begin
                mc_wide = VW'(min_reg) + VW'(digit) * VW'(frac_weight[fds_reg]);
                mc_fds  = fds_reg + 3'd1;
                mc_upd  = 1'b1;
            end
            if (mc_upd)
            begin
                mc_min = (mc_wide > VW'(MAXV)) ? MAXV : mc_wide[MW-1:0];
            end
        end
        else if (rx_byte == ngp_pkg::CHAR_POINT && !point_reg)
        begin
            mc_point = 1'b1;
        end
        else
        begin
            mc_point = 1'b1;
            mc_fds   = ngp_pkg::FRAC_DONE;
        end
    end

    // Per-character state update
    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        field_next       = field_reg;
        cpos_next        = cpos_reg;
        header_ok_next   = header_ok_reg;
        time_next        = time_reg;
        deg_next         = deg_reg;
        min_next         = min_reg;
        fds_next         = fds_reg;
        point_next       = point_reg;
        lat_deg_next     = lat_deg_reg;
        lat_min_next     = lat_min_reg;
        lat_hem_next     = lat_hem_reg;
        lon_hem_next     = lon_hem_reg;
        emit             = 1'b0;

        if (accept)
        begin
            if (rx_byte == ngp_pkg::CHAR_DOLLAR)
            begin
                in_sentence_next = 1'b1;
                field_next       = ngp_pkg::FIELD_HEADER;
                cpos_next        = '0;
                header_ok_next   = 1'b1;
                time_next        = '0;
                deg_next         = '0;
                min_next         = '0;
                fds_next         = '0;
                point_next       = 1'b0;
                lat_deg_next     = '0;
                lat_min_next     = '0;
                lat_hem_next     = '0;
                lon_hem_next     = '0;
            end
            else if (in_sentence_reg)
            begin
                if (rx_byte == ngp_pkg::CHAR_STAR)
                begin
                    in_sentence_next = 1'b0;
                    emit = header_ok_reg && (field_reg >= ngp_pkg::FIELD_DONE);
                end
                else if (rx_byte == ngp_pkg::CHAR_COMMA)
                begin
                    if (field_reg == ngp_pkg::FIELD_HEADER && cpos_reg != ngp_pkg::HEADER_LEN)
                    begin
                        header_ok_next = 1'b0;
                    end
                    // latitude is held raw, converted at the end of the sentence
                    if (field_reg == ngp_pkg::FIELD_LAT)
                    begin
                        lat_deg_next = deg_reg[ngp_pkg::LAT_DEG_W-1:0];
                        lat_min_next = min_reg;
                        deg_next     = '0;
                        min_next     = '0;
                        fds_next     = '0;
                        point_next   = 1'b0;
                    end
                    if (field_reg != ngp_pkg::FIELD_MAX)
                    begin
                        field_next = field_reg + 3'd1;
                    end
                    cpos_next = '0;
                end
                else
                begin
                    case (field_reg)
                        ngp_pkg::FIELD_HEADER:
                        begin
                            if (cpos_reg >= ngp_pkg::HEADER_LEN ||
                                rx_byte != ngp_pkg::header_char(cpos_reg))
                            begin
                                header_ok_next = 1'b0;
                            end
                        end
                        ngp_pkg::FIELD_TIME:
                        begin
                            if (cpos_reg < ngp_pkg::TIME_DIGITS)
                            begin
                                time_next = time_reg + ngp_pkg::TIME_W'(digit) *
                                    ngp_pkg::TIME_W'(ngp_pkg::time_weight(cpos_reg));
                            end
                        end
                        ngp_pkg::FIELD_LAT:
                        begin
                            if (cpos_reg < ngp_pkg::LAT_DEG_DIGITS)
                            begin
                                deg_next = deg_reg + ngp_pkg::LON_DEG_W'(digit) *
                                    ((cpos_reg == 3'd0) ? ngp_pkg::LON_DEG_W'(10)
                                                        : ngp_pkg::LON_DEG_W'(1));
                            end
                            else
                            begin
                                min_next   = mc_min;
                                fds_next   = mc_fds;
                                point_next = mc_point;
                            end
                        end
                        ngp_pkg::FIELD_LAT_HEM:
                        begin
                            if (cpos_reg == 3'd0)
                            begin
                                lat_hem_next = rx_byte;
                            end
                        end
                        ngp_pkg::FIELD_LON:
                        begin
                            if (cpos_reg < ngp_pkg::LON_DEG_DIGITS)
                            begin
                                deg_next = deg_reg + ngp_pkg::LON_DEG_W'(digit) *
                                    ngp_pkg::LON_DEG_W'(ngp_pkg::lon_deg_weight(cpos_reg));
                            end
                            else
                            begin
                                min_next   = mc_min;
                                fds_next   = mc_fds;
                                point_next = mc_point;
                            end
                        end
                        ngp_pkg::FIELD_LON_HEM:
                        begin
                            if (cpos_reg == 3'd0)
                            begin
                                lon_hem_next = rx_byte;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cpos_reg != ngp_pkg::CPOS_MAX)
                    begin
                        cpos_next = cpos_reg + 3'd1;
                    end
                end
            end
        end
    end

    // Result handshake
    always_comb
    begin
        fix_valid_next = fix_valid_reg;
        if (rx_ready)
        begin
            fix_valid_next = accept && emit;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            field_reg       <= ngp_pkg::FIELD_HEADER;
            cpos_reg        <= '0;
            header_ok_reg   <= 1'b1;
            time_reg        <= '0;
            deg_reg         <= '0;
            min_reg         <= '0;
            fds_reg         <= '0;
            point_reg       <= 1'b0;
            lat_deg_reg     <= '0;
            lat_min_reg     <= '0;
            lat_hem_reg     <= '0;
            lon_hem_reg     <= '0;
            fix_valid_reg   <= 1'b0;
        end
        else
        begin
            in_sentence_reg <= in_sentence_next;
            field_reg       <= field_next;
            cpos_reg        <= cpos_next;
            header_ok_reg   <= header_ok_next;
            time_reg        <= time_next;
            deg_reg         <= deg_next;
            min_reg         <= min_next;
            fds_reg         <= fds_next;
            point_reg       <= point_next;
            lat_deg_reg     <= lat_deg_next;
            lat_min_reg     <= lat_min_next;
            lat_hem_reg     <= lat_hem_next;
            lon_hem_reg     <= lon_hem_next;
            fix_valid_reg   <= fix_valid_next;
        end
    end

    // Result payload, captured at the closing star
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            fix_reg.time_seconds <= time_reg;
            fix_reg.lat_deg      <= lat_deg_reg;
            fix_reg.lat_hem      <= lat_hem_reg;
            fix_reg.lon_deg      <= deg_reg;
            fix_reg.lon_hem      <= lon_hem_reg;
            lat_min_out_reg      <= lat_min_reg;
            lon_min_out_reg      <= min_reg;
        end
    end

    assign fix_valid   = fix_valid_reg;
    assign fix         = fix_reg;
    assign lat_minutes = lat_min_out_reg;
    assign lon_minutes = lon_min_out_reg;

endmodule

// File: rtl/ngp_angle_conv.sv
`timescale 1ns / 1ps

// Degrees and minutes to micro-degrees over three register stages.
// Minutes/60 scaled to 1e-6 is reduced to x*NUM/DEN, and the constant
// division is a multiplication by a rounded-up reciprocal and a shift.
module ngp_angle_conv #(
    parameter int MINUTE_FRACTION_DIGITS = ngp_pkg::MINUTE_FRACTION_DIGITS_DEFAULT,
    parameter int DEG_W                  = ngp_pkg::LON_DEG_W
) (
    input  logic                                                  clk,
    input  ngp_pkg::pipe_en_t                                     en,
    input  logic [DEG_W-1:0]                                      deg,
    input  logic [ngp_pkg::minute_w(MINUTE_FRACTION_DIGITS)-1:0]  minutes,
    output logic [ngp_pkg::ANGLE_W-1:0]                           angle
);

    localparam int FD  = MINUTE_FRACTION_DIGITS;
    localparam int MW  = ngp_pkg::minute_w(FD);
    localparam longint unsigned NUM =
        (FD >= 5) ? 1 : 5 * ngp_pkg::pow10((FD >= 5) ? 0 : 4 - FD);
    localparam longint unsigned DEN =
        (FD >= 5) ? 6 * ngp_pkg::pow10((FD >= 5) ? FD - 5 : 0) : 3;
    localparam int XW  = $clog2(100 * ngp_pkg::pow10(FD) * NUM);
    localparam int SH  = XW + $clog2(DEN);
    localparam longint unsigned RECIP = ((64'd1 << SH) + DEN - 1) / DEN;
    localparam int RW  = $clog2(RECIP + 1);
    localparam int PW  = XW + RW;
    localparam int AW  = ngp_pkg::ANGLE_W;

    logic [XW-1:0] x_reg, x_next;
    logic [AW-1:0] degp_a_reg, degp_a_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [AW-1:0] degp_b_reg;
    logic [AW-1:0] angle_reg, angle_next;

    // Stage a: scale minutes, degrees to micro-degrees
    assign x_next      = XW'(minutes) * XW'(NUM);
    assign degp_a_next = AW'(deg) * AW'(ngp_pkg::MICRO);

    // Stage b: reciprocal multiply
    assign prod_next = PW'(x_reg) * PW'(RECIP);

    // Stage o: quotient plus degree part
    assign angle_next = degp_b_reg + AW'(prod_reg >> SH);

    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            x_reg      <= x_next;
            degp_a_reg <= degp_a_next;
        end
        if (en.b)
        begin
            prod_reg   <= prod_next;
            degp_b_reg <= degp_a_reg;
        end
        if (en.o)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// File: rtl/ngp_fix_convert.sv
`timescale 1ns / 1ps

module ngp_fix_convert #(
    parameter int MINUTE_FRACTION_DIGITS = ngp_pkg::MINUTE_FRACTION_DIGITS_DEFAULT
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  ngp_pkg::fix_fields_t                                  fix,
    input  logic [ngp_pkg::minute_w(MINUTE_FRACTION_DIGITS)-1:0]  lat_minutes,
    input  logic [ngp_pkg::minute_w(MINUTE_FRACTION_DIGITS)-1:0]  lon_minutes,
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output logic [ngp_pkg::TIME_W-1:0]                            fix_time_seconds,
    output logic [ngp_pkg::LAT_W-1:0]                             lat_microdeg,
    output logic [ngp_pkg::HEM_W-1:0]                             lat_hemisphere,
    output logic [ngp_pkg::LON_W-1:0]                             lon_microdeg,
    output logic [ngp_pkg::HEM_W-1:0]                             lon_hemisphere
);

    logic                       a_valid_reg, a_valid_next;
    logic                       b_valid_reg, b_valid_next;
    logic                       o_valid_reg, o_valid_next;
    ngp_pkg::fix_fields_t       fix_a_reg;
    ngp_pkg::fix_fields_t       fix_b_reg;
    ngp_pkg::fix_fields_t       fix_o_reg;
    ngp_pkg::pipe_en_t          en;
    logic [ngp_pkg::ANGLE_W-1:0] lat_angle;
    logic [ngp_pkg::ANGLE_W-1:0] lon_angle;

    // Each stage loads when it is empty or its contents move on
    always_comb
    begin
        en.o = !o_valid_reg || out_ready;
        en.b = !b_valid_reg || en.o;
        en.a = !a_valid_reg || en.b;
        a_valid_next = en.a ? in_valid    : a_valid_reg;
        b_valid_next = en.b ? a_valid_reg : b_valid_reg;
        o_valid_next = en.o ? b_valid_reg : o_valid_reg;
    end

    assign in_ready = en.a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Time and hemispheres ride alongside the angle stages
    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            fix_a_reg <= fix;
        end
        if (en.b)
        begin
            fix_b_reg <= fix_a_reg;
        end
        if (en.o)
        begin
            fix_o_reg <= fix_b_reg;
        end
    end

    ngp_angle_conv #(
        .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS),
        .DEG_W                  (ngp_pkg::LAT_DEG_W)
    ) u_lat_conv (
        .clk     (clk),
        .en      (en),
        .deg     (fix.lat_deg),
        .minutes (lat_minutes),
        .angle   (lat_angle)
    );

    ngp_angle_conv #(
        .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS),
        .DEG_W                  (ngp_pkg::LON_DEG_W)
    ) u_lon_conv (
        .clk     (clk),
        .en      (en),
        .deg     (fix.lon_deg),
        .minutes (lon_minutes),
        .angle   (lon_angle)
    );

    assign out_valid        = o_valid_reg;
    assign fix_time_seconds = fix_o_reg.time_seconds;
    assign lat_hemisphere   = fix_o_reg.lat_hem;
    assign lon_hemisphere   = fix_o_reg.lon_hem;
    assign lat_microdeg     = lat_angle[ngp_pkg::LAT_W-1:0];
    assign lon_microdeg     = lon_angle[ngp_pkg::LON_W-1:0];

endmodule

// File: rtl/nmea_gga_position_parser.sv
`timescale 1ns / 1ps

// GGA position parser: takes one received character per transaction and
// accepts a new one every clock cycle while the parser's result register is
// empty or being taken. A '$' opens a sentence; at the '*' of a sentence
// with header GPGGA and all six fields present, one result with the fix
// time in seconds, both angles in micro-degrees and the two hemisphere
// characters is issued. The character parser updates its state for each
// accepted character; the result then passes the parser's output register
// and a three-stage conversion pipeline (constant multiply, reciprocal
// multiply for the minute division, final add) before it reaches the output.
// Every stage has its own valid bit, so characters keep flowing while a
// result waits to be taken.
module nmea_gga_position_parser #(
    parameter int MINUTE_FRACTION_DIGITS = ngp_pkg::MINUTE_FRACTION_DIGITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rx_valid,
    output logic                       rx_ready,
    input  logic [7:0]                 rx_byte,
    output logic                       fix_valid,
    input  logic                       fix_ready,
    output logic [ngp_pkg::TIME_W-1:0] fix_time_seconds,
    output logic [ngp_pkg::LAT_W-1:0]  lat_microdeg,
    output logic [ngp_pkg::HEM_W-1:0]  lat_hemisphere,
    output logic [ngp_pkg::LON_W-1:0]  lon_microdeg,
    output logic [ngp_pkg::HEM_W-1:0]  lon_hemisphere
);

    localparam int MW = ngp_pkg::minute_w(MINUTE_FRACTION_DIGITS);

    logic                  raw_valid;
    logic                  raw_ready;
    ngp_pkg::fix_fields_t  raw_fix;
    logic [MW-1:0]         raw_lat_minutes;
    logic [MW-1:0]         raw_lon_minutes;

    // Character parser
    ngp_char_parser #(
        .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_byte     (rx_byte),
        .fix_valid   (raw_valid),
        .fix_ready   (raw_ready),
        .fix         (raw_fix),
        .lat_minutes (raw_lat_minutes),
        .lon_minutes (raw_lon_minutes)
    );

    // Angle conversion pipeline and result register
    ngp_fix_convert #(
        .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS)
    ) u_convert (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (raw_valid),
        .in_ready         (raw_ready),
        .fix              (raw_fix),
        .lat_minutes      (raw_lat_minutes),
        .lon_minutes      (raw_lon_minutes),
        .out_valid        (fix_valid),
        .out_ready        (fix_ready),
        .fix_time_seconds (fix_time_seconds),
        .lat_microdeg     (lat_microdeg),
        .lat_hemisphere   (lat_hemisphere),
        .lon_microdeg     (lon_microdeg),
        .lon_hemisphere   (lon_hemisphere)
    );

endmodule
